>>> sv/encoder_pid_position_loop_macros.svh
// Assertion helpers shared by the position loop RTL.
`ifndef ENCODER_PID_POSITION_LOOP_MACROS_SVH
`define ENCODER_PID_POSITION_LOOP_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define EPID_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("epid: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define EPID_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("epid: next-cycle check failed");

`endif

>>> sv/epid_pkg.sv
package epid_pkg;

    localparam int GAIN_FRACTION_BITS = 8;

    localparam int POS_W   = 32;
    localparam int ERR_W   = 33;
    localparam int SUM_W   = 48;
    localparam int DIFF_W  = 34;
    localparam int GAIN_W  = 16;
    localparam int BAND_W  = 16;
    localparam int LIMIT_W = 15;
    localparam int DELTA_W = 16;
    localparam int DRIVE_W = 16;
    localparam int ACC_W   = 64;
    localparam int DRV_W   = ACC_W - GAIN_FRACTION_BITS;
    localparam int CFG_W   = 32;
    localparam int IDX_W   = 3;

    localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

    localparam logic [LIMIT_W-1:0] MAX_DRIVE_RESET = LIMIT_W'(100);

    typedef enum logic [IDX_W-1:0] {
        REG_TARGET_POSITION   = 3'd0,
        REG_PROPORTIONAL_GAIN = 3'd1,
        REG_INTEGRAL_GAIN     = 3'd2,
        REG_DERIVATIVE_GAIN   = 3'd3,
        REG_DEAD_BAND         = 3'd4,
        REG_MIN_DRIVE         = 3'd5,
        REG_MAX_DRIVE         = 3'd6,
        REG_ENABLE            = 3'd7
    } cfg_index_t;

    typedef struct packed {
        logic signed [POS_W-1:0]  target_position;
        logic signed [GAIN_W-1:0] proportional_gain;
        logic signed [GAIN_W-1:0] integral_gain;
        logic signed [GAIN_W-1:0] derivative_gain;
        logic [BAND_W-1:0]        dead_band;
        logic [LIMIT_W-1:0]       min_drive;
        logic [LIMIT_W-1:0]       max_drive;
        logic                     enable;
    } cfg_t;

    typedef struct packed {
        logic signed [POS_W-1:0]  shaft_position;
        logic signed [ERR_W-1:0]  last_error;
        logic signed [SUM_W-1:0]  error_sum;
        logic signed [DIFF_W-1:0] last_difference;
    } pid_state_t;

    typedef struct packed {
        logic signed [DRIVE_W-1:0] drive;
        logic                      drive_valid;
        logic                      at_limit;
        logic                      in_dead_band;
        logic signed [POS_W-1:0]   position;
    } result_t;

endpackage

>>> sv/encoder_pid_position_loop.sv
// Channel   Direction  Handshake          Payload
// s_        in         s_valid/s_ready    s_position_change
// m_        out        m_valid/m_ready    m_drive, m_drive_valid, m_at_limit,
//                                         m_in_dead_band, m_position
// cfg_      in         cfg_we             cfg_index, cfg_wdata
//
// One beat is taken per cycle while s_ready is high; each beat passes the input
// register, then the PID step into the result register, before it is presented.
// The PID step, with its three multipliers and the limit tests, sits between
// those two registers and updates the loop state as the beat moves on.
// While the result register is held by a low m_ready the input register still
// fills, so one further beat is taken before s_ready drops.
// Reset (synchronous, active low) clears the loop state and loads register
// defaults; no clearing pass is needed.
`include "encoder_pid_position_loop_macros.svh"

module encoder_pid_position_loop (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic signed [epid_pkg::DELTA_W-1:0]  s_position_change,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic signed [epid_pkg::DRIVE_W-1:0]  m_drive,
    output logic                                 m_drive_valid,
    output logic                                 m_at_limit,
    output logic                                 m_in_dead_band,
    output logic signed [epid_pkg::POS_W-1:0]    m_position,
    input  logic                                 cfg_we,
    input  logic [epid_pkg::IDX_W-1:0]           cfg_index,
    input  logic [epid_pkg::CFG_W-1:0]           cfg_wdata
);

    epid_pkg::cfg_t                         cfg_reg, cfg_next;
    epid_pkg::pid_state_t                   state_reg, state_next, state_step;
    epid_pkg::result_t                      result_reg, result_next;
    logic                                   in_valid_reg, in_valid_next;
    logic signed [epid_pkg::DELTA_W-1:0]    delta_reg, delta_next;
    logic                                   m_valid_reg, m_valid_next;
    logic                                   out_free;
    logic                                   advance;
    logic                                   s_fire;

    assign out_free = !m_valid_reg || m_ready;
    assign advance  = in_valid_reg && out_free;
    assign s_ready  = !in_valid_reg || out_free;
    assign s_fire   = s_valid && s_ready;

    epid_step u_step (
        .cfg_i    (cfg_reg),
        .state_i  (state_reg),
        .delta_i  (delta_reg),
        .state_o  (state_step),
        .result_o (result_next)
    );

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            unique case (epid_pkg::cfg_index_t'(cfg_index))
                epid_pkg::REG_TARGET_POSITION: begin
                    cfg_next.target_position = cfg_wdata[epid_pkg::POS_W-1:0];
                end
                epid_pkg::REG_PROPORTIONAL_GAIN: begin
                    cfg_next.proportional_gain = cfg_wdata[epid_pkg::GAIN_W-1:0];
                end
                epid_pkg::REG_INTEGRAL_GAIN: begin
                    cfg_next.integral_gain = cfg_wdata[epid_pkg::GAIN_W-1:0];
                end
                epid_pkg::REG_DERIVATIVE_GAIN: begin
                    cfg_next.derivative_gain = cfg_wdata[epid_pkg::GAIN_W-1:0];
                end
                epid_pkg::REG_DEAD_BAND: begin
                    cfg_next.dead_band = cfg_wdata[epid_pkg::BAND_W-1:0];
                end
                epid_pkg::REG_MIN_DRIVE: begin
                    cfg_next.min_drive = cfg_wdata[epid_pkg::LIMIT_W-1:0];
                end
                epid_pkg::REG_MAX_DRIVE: begin
                    cfg_next.max_drive = cfg_wdata[epid_pkg::LIMIT_W-1:0];
                end
                epid_pkg::REG_ENABLE: begin
                    cfg_next.enable = cfg_wdata[0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        in_valid_next = in_valid_reg;
        delta_next    = delta_reg;
        if (s_fire) begin
            in_valid_next = 1'b1;
            delta_next    = s_position_change;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        state_next   = state_reg;
        if (advance) begin
            m_valid_next = 1'b1;
            state_next   = state_step;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.target_position   <= '0;
            cfg_reg.proportional_gain <= '0;
            cfg_reg.integral_gain     <= '0;
            cfg_reg.derivative_gain   <= '0;
            cfg_reg.dead_band         <= '0;
            cfg_reg.min_drive         <= '0;
            cfg_reg.max_drive         <= epid_pkg::MAX_DRIVE_RESET;
            cfg_reg.enable            <= 1'b0;
            state_reg                 <= '0;
            in_valid_reg              <= 1'b0;
            m_valid_reg               <= 1'b0;
        end else begin
            cfg_reg      <= cfg_next;
            state_reg    <= state_next;
            in_valid_reg <= in_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        delta_reg <= delta_next;
        if (advance) begin
            result_reg <= result_next;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_drive        = result_reg.drive;
    assign m_drive_valid  = result_reg.drive_valid;
    assign m_at_limit     = result_reg.at_limit;
    assign m_in_dead_band = result_reg.in_dead_band;
    assign m_position     = result_reg.position;

    // A disabled step reports no drive and no flags.
    `EPID_ASSERT_IMP(a_disabled_quiet, aclk, aresetn, m_valid_reg && !m_drive_valid, m_drive == '0 && !m_at_limit && !m_in_dead_band)
    // Inside the dead band the drive is always zero, whatever the limits.
    `EPID_ASSERT_IMP(a_band_zero, aclk, aresetn, m_valid_reg && m_in_dead_band, m_drive == '0 && m_drive_valid)
    // A disabled step leaves the integral untouched.
    `EPID_ASSERT_NEXT(a_sum_hold, aclk, aresetn, advance && !cfg_reg.enable, $stable(state_reg.error_sum))
    // An empty result register never holds back the input side.
    `EPID_ASSERT_IMP(a_ready_when_empty, aclk, aresetn, !m_valid_reg, s_ready)

endmodule

>>> sv/epid_step.sv
module epid_step (
    input  epid_pkg::cfg_t                          cfg_i,
    input  epid_pkg::pid_state_t                    state_i,
    input  logic signed [epid_pkg::DELTA_W-1:0]     delta_i,
    output epid_pkg::pid_state_t                    state_o,
    output epid_pkg::result_t                       result_o
);

    logic signed [epid_pkg::POS_W-1:0]            pos;
    logic signed [epid_pkg::ERR_W-1:0]            err_raw;
    logic signed [epid_pkg::ERR_W-1:0]            err;
    logic [epid_pkg::ERR_W-1:0]                   mag_err;
    logic                                         in_band;
    logic signed [epid_pkg::GAIN_W+epid_pkg::ERR_W-1:0]  prod_p;
    logic signed [epid_pkg::ACC_W-1:0]                   prod_i;
    logic signed [epid_pkg::GAIN_W+epid_pkg::DIFF_W-1:0] prod_d;
    logic signed [epid_pkg::ACC_W-1:0]            acc;
    logic signed [epid_pkg::DRV_W-1:0]            drive_raw;
    logic [epid_pkg::DRV_W-1:0]                   mag;
    logic                                         neg;
    logic                                         nonzero;
    logic                                         limit;
    logic                                         sum_upd;
    logic signed [epid_pkg::DRIVE_W-1:0]          drive;
    logic signed [epid_pkg::SUM_W:0]              sum_wide;
    logic signed [epid_pkg::SUM_W-1:0]            sum_sat;

    assign pos     = state_i.shaft_position + epid_pkg::POS_W'(delta_i);
    assign err_raw = epid_pkg::ERR_W'(cfg_i.target_position) - epid_pkg::ERR_W'(pos);
    assign mag_err = err_raw[epid_pkg::ERR_W-1] ? epid_pkg::ERR_W'(-err_raw)
                                                : epid_pkg::ERR_W'(err_raw);
    assign in_band = mag_err <= epid_pkg::ERR_W'(cfg_i.dead_band);
    assign err     = in_band ? '0 : err_raw;

    // Three independent products, each at its natural width.
    assign prod_p = cfg_i.proportional_gain * err_raw;
    assign prod_i = cfg_i.integral_gain * state_i.error_sum;
    assign prod_d = cfg_i.derivative_gain * state_i.last_difference;
    assign acc    = epid_pkg::ACC_W'(prod_p) + prod_i + epid_pkg::ACC_W'(prod_d);

    always_comb begin
        // The arithmetic shift rounds towards minus infinity, as required.
        drive_raw = in_band ? '0
                  : epid_pkg::DRV_W'(acc >>> epid_pkg::GAIN_FRACTION_BITS);
        neg       = drive_raw[epid_pkg::DRV_W-1];
        nonzero   = |drive_raw;
        mag       = neg ? epid_pkg::DRV_W'(-drive_raw) : epid_pkg::DRV_W'(drive_raw);
        limit     = 1'b0;
        sum_upd   = 1'b0;
        if (mag >= epid_pkg::DRV_W'(cfg_i.max_drive)) begin
            limit = 1'b1;
            drive = neg ? -epid_pkg::DRIVE_W'(cfg_i.max_drive)
                  : (nonzero ? epid_pkg::DRIVE_W'(cfg_i.max_drive) : '0);
        end else if (mag < epid_pkg::DRV_W'(cfg_i.min_drive)) begin
            drive = neg ? -epid_pkg::DRIVE_W'(cfg_i.min_drive)
                  : (nonzero ? epid_pkg::DRIVE_W'(cfg_i.min_drive) : '0);
        end else begin
            // Magnitude is below max_drive here, so the low bits hold it.
            drive   = drive_raw[epid_pkg::DRIVE_W-1:0];
            sum_upd = 1'b1;
        end
    end

    always_comb begin
        sum_wide = (epid_pkg::SUM_W+1)'(state_i.error_sum) + (epid_pkg::SUM_W+1)'(err);
        if (sum_wide[epid_pkg::SUM_W] != sum_wide[epid_pkg::SUM_W-1]) begin
            sum_sat = sum_wide[epid_pkg::SUM_W] ? epid_pkg::SUM_MIN : epid_pkg::SUM_MAX;
        end else begin
            sum_sat = sum_wide[epid_pkg::SUM_W-1:0];
        end
    end

    always_comb begin
        state_o                = state_i;
        state_o.shaft_position = pos;
        result_o.position      = pos;
        result_o.drive_valid   = cfg_i.enable;
        if (cfg_i.enable) begin
            result_o.drive          = drive;
            result_o.at_limit       = limit;
            result_o.in_dead_band   = in_band;
            state_o.last_error      = err;
            state_o.last_difference = epid_pkg::DIFF_W'(err)
                                    - epid_pkg::DIFF_W'(state_i.last_error);
            if (sum_upd) begin
                state_o.error_sum = sum_sat;
            end
        end else begin
            result_o.drive        = '0;
            result_o.at_limit     = 1'b0;
            result_o.in_dead_band = 1'b0;
        end
    end

endmodule
